>>> design/velocity_feedback_thrust_trim_unit_defines.svh
// assertion macros shared by the thrust trim checks
`ifndef VELOCITY_FEEDBACK_THRUST_TRIM_UNIT_DEFINES_SVH
`define VELOCITY_FEEDBACK_THRUST_TRIM_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define VFTT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define VFTT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/vftt_pkg.sv
// shared types and constants of the velocity feedback thrust trim unit
package vftt_pkg;

  // fixed point formats
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 24;
  localparam int ERR_FRAC   = 20;
  localparam int GAIN_FRAC  = 32;
  localparam int PROD_SHIFT = GAIN_FRAC + ERR_FRAC - FRAC_BITS;

  // serial multiplier geometry
  localparam int MCAND_W    = 56;
  localparam int MPLIER_W   = 32;
  localparam int DIGIT_W    = 8;
  localparam int MUL_DIGITS = MPLIER_W / DIGIT_W;
  localparam int PROD_W     = MCAND_W + MPLIER_W;

  // working accumulator holds a signed rounded product plus small terms
  localparam int ACC_W = PROD_W - PROD_SHIFT + 2;

  // engine count times per-engine thrust, and the clamp limit
  localparam int NT_W  = 35;
  localparam int LIM_W = DATA_WIDTH - 1;
  localparam logic [LIM_W-1:0] DMAX = '1;

  // apb register map
  localparam int APB_ADDR_W = 5;
  localparam logic [30:0] THRUST_MAX_RESET = 31'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    REG_LOOP_ENABLE,
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_FILTER_COEFF,
    REG_THRUST_MIN,
    REG_THRUST_MAX
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] vel_error;
    logic        [23:0] mass;
    logic signed [31:0] thrust_nominal;
    logic        [3:0]  engine_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] thrust_cmd;
    logic               integ_limited;
    logic               output_limited;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [MCAND_W-1:0]  mcand;
    logic [MPLIER_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic            start;
    logic [NT_W-1:0] max_total;
  } lim_req_t;

  typedef struct packed {
    logic             valid;
    logic [LIM_W-1:0] lim;
  } lim_rsp_t;

endpackage

>>> design/vftt_mul.sv
// digit serial unsigned multiplier, one 8-bit multiplier digit per cycle
module vftt_mul import vftt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MUL_DIGITS);
  localparam int SUM_W = MCAND_W + DIGIT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_DIGITS - 1);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [MCAND_W-1:0]  mcand;
  logic [MPLIER_W-1:0] mplier;
  logic [MCAND_W-1:0]  hi;
  logic [MPLIER_W-1:0] lo;
  logic [SUM_W-1:0]    sum;

  // partial product of the low digit added to the upper half
  assign sum = SUM_W'(hi) + SUM_W'(mcand) * SUM_W'(mplier[DIGIT_W-1:0]);

  // digit count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == CNT_LAST);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // shift-add datapath, low product bits shift out into lo
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand  <= req.mcand;
      mplier <= req.mplier;
      hi     <= '0;
      lo     <= '0;
    end else if (busy) begin
      hi     <= sum[SUM_W-1:DIGIT_W];
      lo     <= {sum[DIGIT_W-1:0], lo[MPLIER_W-1:DIGIT_W]};
      mplier <= mplier >> DIGIT_W;
    end
  end

  assign rsp.done    = done;
  assign rsp.product = {hi, lo};

endmodule

>>> design/vftt_lim.sv
// integrator clamp limit, round(3 * total max thrust / 20), divided one nibble a cycle
module vftt_lim import vftt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  lim_req_t req,
  output lim_rsp_t rsp
);

  localparam int X_W         = NT_W + 2;
  localparam int DIV_W       = 36;
  localparam int NIB_W       = 4;
  localparam int DIV_STEPS   = DIV_W / NIB_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int LIM_NUM     = 3;
  localparam int HALF_DEN    = 10;
  localparam int DEN_SHIFT   = 2;
  localparam int RECIP5      = 205;
  localparam int RECIP_SHIFT = 10;
  localparam int DIV5        = 5;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic             busy;
  logic             valid;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] y;
  logic [DIV_W-1:0] q;
  logic [2:0]       rem;
  logic [LIM_W-1:0] lim;
  logic [X_W-1:0]   x;
  logic [6:0]       t;
  logic [14:0]      tq;
  logic [3:0]       qd;
  logic [6:0]       tr;
  logic [DIV_W-1:0] q_next;

  // numerator with half the divisor added, then the power of two part taken out
  assign x = X_W'(LIM_NUM) * X_W'(req.max_total) + X_W'(HALF_DEN);

  // one quotient digit of a divide by five, remainder stays below five
  assign t      = {rem, y[DIV_W-1 -: NIB_W]};
  assign tq     = 15'(t) * 15'(RECIP5);
  assign qd     = tq[RECIP_SHIFT +: 4];
  assign tr     = t - 7'(qd) * 7'(DIV5);
  assign q_next = {q[DIV_W-NIB_W-1:0], qd};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_LAST) begin
        busy  <= 1'b0;
        valid <= 1'b1;
      end
    end
  end

  // datapath, limit capped at the largest positive data word
  always_ff @(posedge clk) begin
    if (req.start) begin
      y   <= DIV_W'(x >> DEN_SHIFT);
      q   <= '0;
      rem <= '0;
    end else if (busy) begin
      y   <= y << NIB_W;
      q   <= q_next;
      rem <= tr[2:0];
      if (cnt == CNT_LAST) begin
        lim <= (q_next > DIV_W'(DMAX)) ? DMAX : q_next[LIM_W-1:0];
      end
    end
  end

  assign rsp.valid = valid;
  assign rsp.lim   = lim;

endmodule

>>> design/velocity_feedback_thrust_trim_unit.sv
// top level of the velocity feedback thrust trim unit
// A PI thrust trim with a low-pass filter on the velocity error and a clamped
// integrator. One input beat is taken at a time. A tick with the loop disabled
// or zero engines goes from acceptance straight to the output state and returns
// the nominal thrust as soon as the output register is free. A feedback tick
// makes four passes through one shared multiplier that consumes an 8-bit
// multiplier digit per cycle (filter product, mass times filtered error, then
// the integral and proportional gains), with register stages for the filter
// update and the two clamps in between. The integrator limit is divided out
// by five one nibble a cycle in parallel with the first passes. A finished
// result sits in the output register while the next beat is accepted.
// Configuration registers sit on the APB port at byte address 4 * index.
`include "velocity_feedback_thrust_trim_unit_defines.svh"

module velocity_feedback_thrust_trim_unit import vftt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int DIFF_W  = 33;
  localparam int COEFF_W = 16;
  localparam int FP_W    = DIFF_W + COEFF_W;
  localparam int FMAG_W  = FP_W + 1 - COEFF_W;
  localparam logic [FP_W:0] FRND_POS = (FP_W + 1)'(1) << (COEFF_W - 1);
  localparam logic [FP_W:0] FRND_NEG = FRND_POS - (FP_W + 1)'(1);
  localparam logic [PROD_W:0] PROD_RND = (PROD_W + 1)'(1) << (PROD_SHIFT - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILT,
    S_FILT_W,
    S_FUPD,
    S_MF,
    S_MF_W,
    S_INT_W,
    S_ICLAMP,
    S_PROP_W,
    S_OCLAMP,
    S_OUT
  } state_t;

  // sign extend a data word to the accumulator width
  function automatic logic [ACC_W-1:0] sext_word(input logic [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

  // saturate an accumulator value to a signed data word
  function automatic logic [31:0] sat_word(input logic [ACC_W-1:0] v);
    if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
      return v[31:0];
    end
    return v[ACC_W-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
  endfunction

  // configuration registers
  logic        loop_enable;
  logic [31:0] prop_gain;
  logic [31:0] integ_gain;
  logic [15:0] filter_coeff;
  logic [30:0] thrust_min_each;
  logic [30:0] thrust_max_each;

  // control and state
  state_t             state;
  logic signed [31:0] filtered_error;
  logic signed [31:0] integrator;

  // working registers of one tick
  logic signed [31:0]       err_r;
  logic [23:0]              mass_r;
  logic signed [31:0]       nom_r;
  logic [NT_W-1:0]          ntmax;
  logic [NT_W-1:0]          ntmin;
  logic [NT_W-1:0]          hi_bound;
  logic                     d_neg;
  logic                     f_neg;
  logic [MCAND_W-1:0]       mf;
  logic signed [ACC_W-1:0]  acc;
  logic signed [31:0]       res_cmd;
  logic                     res_ilim;
  logic                     res_olim;

  // combinational datapath
  logic                     wr_en;
  logic [2:0]               reg_sel;
  logic                     accept;
  logic                     bypass;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_mag;
  logic [31:0]              f_mag;
  logic [PROD_W-1:0]        prod;
  logic [FP_W:0]            fp_rnd;
  logic [FMAG_W-1:0]        fstep_mag;
  logic signed [ACC_W-1:0]  fsum;
  logic [PROD_W:0]          prod_rnd;
  logic signed [ACC_W-1:0]  sp;
  logic signed [ACC_W-1:0]  lim_p;
  logic signed [ACC_W-1:0]  lim_n;
  logic signed [ACC_W-1:0]  tmin_s;
  logic signed [ACC_W-1:0]  hb_s;
  logic signed [ACC_W-1:0]  c1;
  logic signed [ACC_W-1:0]  c2;
  logic                     lo_hit;
  logic                     hi_hit;
  logic signed [ACC_W-1:0]  integ_ext;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  lim_req_t lim_req;
  lim_rsp_t lim_rsp;

  vftt_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  vftt_lim u_lim (
    .clk (clk),
    .rst (rst),
    .req (lim_req),
    .rsp (lim_rsp)
  );

  // apb register file
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable     <= 1'b0;
      prop_gain       <= '0;
      integ_gain      <= '0;
      filter_coeff    <= '0;
      thrust_min_each <= '0;
      thrust_max_each <= THRUST_MAX_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LOOP_ENABLE:  loop_enable     <= pwdata[0];
        REG_PROP_GAIN:    prop_gain       <= pwdata;
        REG_INTEG_GAIN:   integ_gain      <= pwdata;
        REG_FILTER_COEFF: filter_coeff    <= pwdata[15:0];
        REG_THRUST_MIN:   thrust_min_each <= pwdata[30:0];
        REG_THRUST_MAX:   thrust_max_each <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOOP_ENABLE:  prdata = 32'(loop_enable);
      REG_PROP_GAIN:    prdata = prop_gain;
      REG_INTEG_GAIN:   prdata = integ_gain;
      REG_FILTER_COEFF: prdata = 32'(filter_coeff);
      REG_THRUST_MIN:   prdata = 32'(thrust_min_each);
      REG_THRUST_MAX:   prdata = 32'(thrust_max_each);
      default:          prdata = '0;
    endcase
  end

  // input handshake
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign bypass   = !loop_enable || (in_data.engine_count == '0);

  // filter operand: error minus filtered error, as sign and magnitude
  assign diff     = $signed({err_r[31], err_r}) - $signed({filtered_error[31], filtered_error});
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign f_mag    = filtered_error[31] ? 32'(-filtered_error) : 32'(filtered_error);
  assign prod     = mul_rsp.product;

  // filter step rounded half up: negative side rounds from one below
  assign fp_rnd    = {1'b0, prod[FP_W-1:0]} + (d_neg ? FRND_NEG : FRND_POS);
  assign fstep_mag = fp_rnd[FP_W:COEFF_W];
  assign fsum      = $signed(sext_word(filtered_error)) + acc;

  // gain product rounded half away from zero, its magnitude stays below 2^59
  assign prod_rnd = {1'b0, prod} + PROD_RND;
  assign sp = f_neg ? -$signed({1'b0, prod_rnd[PROD_W:PROD_SHIFT]})
                    : $signed({1'b0, prod_rnd[PROD_W:PROD_SHIFT]});

  // integrator bounds
  assign lim_p     = $signed({{(ACC_W-LIM_W){1'b0}}, lim_rsp.lim});
  assign lim_n     = -lim_p;
  assign integ_ext = $signed(sext_word(integrator));

  // output clamp: lower bound first, then the upper bound capped at the word max;
  // the result is never negative since the lower bound is not
  assign tmin_s = $signed({{(ACC_W-NT_W){1'b0}}, ntmin});
  assign hb_s   = $signed({{(ACC_W-NT_W){1'b0}}, hi_bound});
  assign lo_hit = acc < tmin_s;
  assign c1     = lo_hit ? tmin_s : acc;
  assign hi_hit = c1 > hb_s;
  assign c2     = hi_hit ? hb_s : c1;

  // multiplier operand select
  always_comb begin
    mul_req.start  = 1'b0;
    mul_req.mcand  = mf;
    mul_req.mplier = prop_gain;
    case (state)
      S_FILT: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = MCAND_W'(diff_mag);
        mul_req.mplier = MPLIER_W'(filter_coeff);
      end
      S_MF: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = MCAND_W'(mass_r);
        mul_req.mplier = f_mag;
      end
      S_MF_W: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = prod[MCAND_W-1:0];
        mul_req.mplier = integ_gain;
      end
      S_ICLAMP: begin
        mul_req.start  = 1'b1;
      end
      default: ;
    endcase
  end

  assign lim_req.start     = (state == S_FILT);
  assign lim_req.max_total = ntmax;

  // sequencer, state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      filtered_error <= '0;
      integrator     <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            err_r  <= in_data.vel_error;
            mass_r <= in_data.mass;
            nom_r  <= in_data.thrust_nominal;
            ntmax  <= NT_W'(in_data.engine_count) * NT_W'(thrust_max_each);
            ntmin  <= NT_W'(in_data.engine_count) * NT_W'(thrust_min_each);
            if (bypass) begin
              res_cmd  <= in_data.thrust_nominal;
              res_ilim <= 1'b0;
              res_olim <= 1'b0;
              state    <= S_OUT;
            end else begin
              state <= S_FILT;
            end
          end
        end
        S_FILT: begin
          d_neg    <= diff[DIFF_W-1];
          hi_bound <= (ntmax > NT_W'(DMAX)) ? NT_W'(DMAX) : ntmax;
          state    <= S_FILT_W;
        end
        S_FILT_W: begin
          if (mul_rsp.done) begin
            acc   <= d_neg ? -ACC_W'(fstep_mag) : ACC_W'(fstep_mag);
            state <= S_FUPD;
          end
        end
        S_FUPD: begin
          filtered_error <= sat_word(fsum);
          state          <= S_MF;
        end
        S_MF: begin
          f_neg <= filtered_error[31];
          state <= S_MF_W;
        end
        S_MF_W: begin
          if (mul_rsp.done) begin
            mf    <= prod[MCAND_W-1:0];
            state <= S_INT_W;
          end
        end
        S_INT_W: begin
          if (mul_rsp.done) begin
            acc   <= integ_ext + sp;
            state <= S_ICLAMP;
          end
        end
        S_ICLAMP: begin
          if (acc > lim_p) begin
            integrator <= lim_p[31:0];
            res_ilim   <= 1'b1;
          end else if (acc < lim_n) begin
            integrator <= lim_n[31:0];
            res_ilim   <= 1'b1;
          end else begin
            integrator <= acc[31:0];
            res_ilim   <= 1'b0;
          end
          state <= S_PROP_W;
        end
        S_PROP_W: begin
          if (mul_rsp.done) begin
            acc   <= $signed(sext_word(nom_r)) + sp + integ_ext;
            state <= S_OCLAMP;
          end
        end
        S_OCLAMP: begin
          res_cmd  <= c2[31:0];
          res_olim <= lo_hit || hi_hit;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.thrust_cmd     <= res_cmd;
            out_data.integ_limited  <= res_ilim;
            out_data.output_limited <= res_olim;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `VFTT_ASSERT_IMP(a_lim_ready, state == S_ICLAMP, lim_rsp.valid, "clamp limit not ready at integrator clamp")
  `VFTT_ASSERT_IMP(a_mul_done_waited, mul_rsp.done, state == S_FILT_W || state == S_MF_W || state == S_INT_W || state == S_PROP_W, "multiplier finished outside a wait state")
  `VFTT_ASSERT_NXT(a_integ_bounded, state == S_ICLAMP, integ_ext <= lim_p && integ_ext >= lim_n, "integrator outside its clamp")
  `VFTT_ASSERT_NXT(a_bypass_direct, accept && bypass, state == S_OUT, "bypass beat did not go straight to output")

endmodule

>>> verif/velocity_feedback_thrust_trim_unit_tb.sv
// self-checking testbench of the velocity feedback thrust trim unit
module velocity_feedback_thrust_trim_unit_tb;
  import vftt_pkg::*;

  localparam int     HALF_PERIOD = 5;
  localparam int     IDLE_PAD    = 40;
  localparam int     HOLD_AT     = 300;
  localparam int     HOLD_LEN    = 500;
  localparam int     MAX_REPORTS = 10;
  localparam int     RUN_LIMIT   = 5_000_000;
  localparam longint DMAX_L      = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint DMIN_L      = -DMAX_L - 1;
  localparam longint ERR_MAX     = 2147483647;
  localparam longint ERR_MIN     = -ERR_MAX - 1;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;

  velocity_feedback_thrust_trim_unit dut (.*);

  // shadow copy of the register file
  logic        cfg_loop_en      = 1'b0;
  logic [31:0] cfg_prop_gain    = '0;
  logic [31:0] cfg_integ_gain   = '0;
  logic [15:0] cfg_filter_coeff = '0;
  logic [30:0] cfg_thrust_min   = '0;
  logic [30:0] cfg_thrust_max   = THRUST_MAX_RESET;

  // controller state: filtered error in Q12.20, integrator in Q8.24
  longint filt_err_q = 0;
  longint integ_q    = 0;

  in_item_t  pending_ticks[$];
  out_item_t trim_expect[$];
  out_item_t exp_beat;

  int mismatch_count = 0;
  int results_seen   = 0;
  int ticks_sent     = 0;
  int feedback_ticks = 0;
  int integ_clamps   = 0;
  int out_sats       = 0;
  int settings_count = 0;

  logic in_taken   = 1'b0;
  int   burst_left = 1;
  int   gap_left   = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;
  int   ready_mode = 0;
  int   ready_left = 0;

  // clock
  initial begin
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // round(gain_mass * |x| / 2^PROD_SHIFT) with halves away from zero, capped at 2^61
  function automatic longint scale_to_thrust(logic [63:0] gain_mass, longint x);
    logic [127:0] prod;
    longint       mag;
    longint       q;
    mag  = (x < 0) ? -x : x;
    prod = {64'd0, gain_mass} * {64'd0, mag};
    prod = (prod + (128'd1 << (PROD_SHIFT - 1))) >> PROD_SHIFT;
    if (prod > (128'd1 << 61)) prod = 128'd1 << 61;
    q = prod[63:0];
    return (x < 0) ? -q : q;
  endfunction

  // one control tick: filter, integrate with clamp, add proportional term, saturate
  function automatic out_item_t trim_thrust(in_item_t t);
    out_item_t   res;
    longint      err;
    longint      n;
    longint      delta;
    longint      lim;
    longint      lo;
    longint      hi;
    longint      cmd;
    logic [63:0] gm;
    res = '0;
    if (!cfg_loop_en || t.engine_count == 0) begin
      res.thrust_cmd = t.thrust_nominal;
      return res;
    end
    feedback_ticks++;
    err = longint'($signed(t.vel_error));
    n   = longint'(t.engine_count);

    // low-pass, rounded half up, held to 32 bits signed
    delta = ((err - filt_err_q) * longint'(cfg_filter_coeff) + 32768) >>> 16;
    filt_err_q = filt_err_q + delta;
    if (filt_err_q > ERR_MAX) filt_err_q = ERR_MAX;
    if (filt_err_q < ERR_MIN) filt_err_q = ERR_MIN;

    // integrator with anti-windup clamp at 0.15 of total max thrust
    gm = 64'(cfg_integ_gain);
    gm = gm * 64'(t.mass);
    integ_q = integ_q + scale_to_thrust(gm, filt_err_q);
    lim = (3 * n * longint'(cfg_thrust_max) + 10) / 20;
    if (lim > DMAX_L) lim = DMAX_L;
    if (integ_q > lim) begin
      integ_q = lim;
      res.integ_limited = 1'b1;
    end
    if (integ_q < -lim) begin
      integ_q = -lim;
      res.integ_limited = 1'b1;
    end

    // command, lower bound first so inverted limits end at the upper one
    gm = 64'(cfg_prop_gain);
    gm = gm * 64'(t.mass);
    cmd = longint'($signed(t.thrust_nominal)) + scale_to_thrust(gm, filt_err_q) + integ_q;
    lo = n * longint'(cfg_thrust_min);
    hi = n * longint'(cfg_thrust_max);
    if (cmd < lo) begin
      cmd = lo;
      res.output_limited = 1'b1;
    end
    if (cmd > hi) begin
      cmd = hi;
      res.output_limited = 1'b1;
    end
    if (cmd > DMAX_L) begin
      cmd = DMAX_L;
      res.output_limited = 1'b1;
    end
    if (cmd < DMIN_L) begin
      cmd = DMIN_L;
      res.output_limited = 1'b1;
    end
    res.thrust_cmd = cmd[31:0];
    if (res.integ_limited) integ_clamps++;
    if (res.output_limited) out_sats++;
    return res;
  endfunction

  // register write: setup cycle then access cycle
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_LOOP_ENABLE:  cfg_loop_en      = value[0];
      REG_PROP_GAIN:    cfg_prop_gain    = value;
      REG_INTEG_GAIN:   cfg_integ_gain   = value;
      REG_FILTER_COEFF: cfg_filter_coeff = value[15:0];
      REG_THRUST_MIN:   cfg_thrust_min   = value[30:0];
      REG_THRUST_MAX:   cfg_thrust_max   = value[30:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic le, logic [31:0] pg, logic [31:0] ig,
                                logic [15:0] fc, logic [30:0] tmin, logic [30:0] tmax);
    write_reg(REG_LOOP_ENABLE, {31'd0, le});
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_INTEG_GAIN, ig);
    write_reg(REG_FILTER_COEFF, {16'd0, fc});
    write_reg(REG_THRUST_MIN, {1'b0, tmin});
    write_reg(REG_THRUST_MAX, {1'b0, tmax});
    settings_count++;
  endtask

  // gains spread over many octaves, limits mostly ordered
  task automatic random_settings();
    logic [31:0] pg;
    logic [31:0] ig;
    logic [15:0] fc;
    logic [30:0] tmin;
    logic [30:0] tmax;
    pg   = $urandom >> $urandom_range(0, 31);
    ig   = $urandom >> $urandom_range(0, 31);
    fc   = 16'($urandom_range(0, 65535));
    tmax = 31'($urandom_range(1 << 22, 1 << 26));
    tmin = 31'($urandom_range(0, 32'(tmax)));
    if ($urandom_range(0, 7) == 0) tmin = 31'($urandom);
    apply_settings(1'b1, pg, ig, fc, tmin, tmax);
  endtask

  task automatic push_tick(logic [31:0] err, logic [23:0] mass, logic [31:0] nom,
                           logic [3:0] n);
    in_item_t t;
    t.vel_error      = err;
    t.mass           = mass;
    t.thrust_nominal = nom;
    t.engine_count   = n;
    pending_ticks.push_back(t);
  endtask

  // mix of full-range and realistic magnitudes
  task automatic random_ticks(int count);
    logic [31:0] err;
    logic [31:0] nom;
    logic [23:0] mass;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) err = $urandom;
      else err = $signed($urandom) >>> $urandom_range(6, 22);
      if ($urandom_range(0, 3) == 0) mass = 24'($urandom);
      else mass = 24'($urandom_range(1, 4000));
      if ($urandom_range(0, 3) == 0) nom = $urandom;
      else nom = $urandom_range(0, 1 << 25);
      push_tick(err, mass, nom, 4'($urandom_range(0, 15)));
    end
  endtask

  // drain everything in flight, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_ticks.size() != 0 || in_valid || trim_expect.size() != 0);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  // input driver: bursts of beats separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        in_data  <= pending_ticks.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left <= $urandom_range(40, 120);
          gap_left   <= 0;
        end else begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) :
                                                      $urandom_range(5, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver: one long hold-off, otherwise switching stall patterns
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        ready_left <= $urandom_range(20, 200);
      end else begin
        ready_left <= ready_left - 1;
      end
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      trim_expect.push_back(trim_thrust(in_data));
      ticks_sent++;
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (trim_expect.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result beat: cmd %h ilim %b olim %b",
                   out_data.thrust_cmd, out_data.integ_limited, out_data.output_limited);
      end else begin
        exp_beat = trim_expect.pop_front();
        if (out_data.thrust_cmd !== exp_beat.thrust_cmd ||
            out_data.integ_limited !== exp_beat.integ_limited ||
            out_data.output_limited !== exp_beat.output_limited) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result %0d: cmd %h/%h ilim %b/%b olim %b/%b (exp/got)",
                     results_seen, exp_beat.thrust_cmd, out_data.thrust_cmd,
                     exp_beat.integ_limited, out_data.integ_limited,
                     exp_beat.output_limited, out_data.output_limited);
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // reset settings leave the loop off: every tick passes nominal through
    push_tick(32'h7fff_ffff, 24'hff_ffff, 32'h7fff_ffff, 4'hf);
    push_tick(32'h8000_0000, 24'h00_0000, 32'h8000_0000, 4'h0);
    push_tick(32'h0000_0000, 24'h00_0001, 32'h0100_0000, 4'h1);
    wait_idle();

    // unit mass and half-lsb gains hit the rounding ties of both signs
    apply_settings(1'b1, 32'h0800_0000, 32'h0800_0000, 16'h8000, 31'd0, THRUST_MAX_RESET);
    push_tick(32'd2, 24'd1, 32'd0, 4'd1);
    push_tick(32'hffff_fffc, 24'd1, 32'd0, 4'd1);
    push_tick(32'd3, 24'd1, 32'd0, 4'd1);
    push_tick(32'hffff_fffd, 24'd1, 32'd0, 4'd1);
    wait_idle();

    // integrator clamp both ways, output saturation both ways, bypass on zero engines
    apply_settings(1'b1, 32'h0040_0000, 32'h0010_0000, 16'hffff, 31'h0040_0000,
                   THRUST_MAX_RESET);
    push_tick(32'h7fff_ffff, 24'hff_ffff, 32'h0100_0000, 4'hf);
    push_tick(32'h7fff_ffff, 24'hff_ffff, 32'h0100_0000, 4'hf);
    push_tick(32'h8000_0000, 24'hff_ffff, 32'h0100_0000, 4'hf);
    push_tick(32'h8000_0000, 24'hff_ffff, 32'h8000_0000, 4'hf);
    push_tick(32'h8000_0000, 24'hff_ffff, 32'h7fff_ffff, 4'h0);
    push_tick(32'h0000_0000, 24'h00_0000, 32'h0100_0000, 4'h1);
    push_tick(32'h0000_0000, 24'h00_0000, 32'h8000_0000, 4'h1);
    wait_idle();

    // minimum above maximum: the upper bound wins
    apply_settings(1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 31'h7fff_ffff,
                   THRUST_MAX_RESET);
    push_tick(32'h0010_0000, 24'd100, 32'h0000_0000, 4'd2);
    push_tick(32'hfff0_0000, 24'd100, 32'h8000_0000, 4'd3);
    push_tick(32'h0000_0000, 24'd0, 32'h7fff_ffff, 4'd1);
    wait_idle();

    // widest limits: clamp limit and command beyond the signed data range
    apply_settings(1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 31'd0, 31'h7fff_ffff);
    push_tick(32'h7fff_ffff, 24'hff_ffff, 32'h7fff_ffff, 4'hf);
    push_tick(32'h7fff_ffff, 24'hff_ffff, 32'h7fff_ffff, 4'hf);
    push_tick(32'h8000_0000, 24'hff_ffff, 32'h8000_0000, 4'hf);
    push_tick(32'h8000_0000, 24'hff_ffff, 32'h0000_0000, 4'hf);
    wait_idle();

    // random phases, each under its own settings
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       apply_settings(1'b1, '1, '1, '1, 31'd0, '1);
        1:       apply_settings(1'b1, '0, '0, '0, 31'd0, 31'd0);
        3:       apply_settings(1'b0, $urandom, $urandom, 16'($urandom), 31'd0,
                                THRUST_MAX_RESET);
        default: random_settings();
      endcase
      random_ticks((p == 3) ? 50 : 150);
      wait_idle();
    end

    $display("covered %0d ticks (%0d with feedback) under %0d register settings",
             ticks_sent, feedback_ticks, settings_count);
    $display("integrator clamped on %0d ticks, command saturated on %0d, %0d mismatches",
             integ_clamps, out_sats, mismatch_count);
    if (mismatch_count == 0 && trim_expect.size() == 0) begin
      $display("velocity_feedback_thrust_trim_unit_tb passed");
    end else begin
      $display("velocity_feedback_thrust_trim_unit_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("run did not complete in time, %0d results still expected", trim_expect.size());
    $display("velocity_feedback_thrust_trim_unit_tb failed");
    $finish;
  end

endmodule
